@@ sv/ipm_pkg.sv @@
// Shared types, register indexes and fixed-point constants of the pixel mapper.
`default_nettype none
package ipm_pkg;

  // Default widths of the pixel beat fields.
  localparam int CoordBitsDef = 11;
  localparam int PixelBitsDef = 8;

  // Configuration port geometry.
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;
  localparam int FocalW   = 31;
  localparam logic [FocalW-1:0] FocalReset = FocalW'(65536);

  typedef enum logic [CfgIdxW-1:0] {
    REG_H_SIN_TILT   = 3'd0,
    REG_COS_TILT     = 3'd1,
    REG_F_H_COS_TILT = 3'd2,
    REG_F_SIN_TILT   = 3'd3,
    REG_FOCAL_LENGTH = 3'd4
  } cfg_idx_e;

  // Camera geometry terms in Q16.16; the focal length is unsigned Q15.16.
  typedef struct packed {
    logic [31:0]       h_sin_tilt;
    logic [31:0]       cos_tilt;
    logic [31:0]       f_h_cos_tilt;
    logic [31:0]       f_sin_tilt;
    logic [FocalW-1:0] focal_length;
  } cfg_t;

  // Fixed-point layout.
  localparam int FracW     = 16;
  localparam int FracMask  = 65535;
  localparam int ZqW       = 20;  // depth in Q4.16, below 10.0
  localparam int RowW      = 9;
  localparam int ColW      = 9;
  localparam int ColDvdW   = 40;  // 300 * focal_length stays below this
  localparam int PixOutW   = 8;

  // Ground window and bird's-eye scaling.
  localparam int DepthMax = 10;
  localparam int LatMax   = 3;
  localparam int Scale    = 50;
  localparam int RowBase  = 500;
  localparam int ColBase  = 150;

endpackage
`default_nettype wire

@@ sv/ipm_pix_if.sv @@
// Channel interface carrying one camera pixel per beat.
`default_nettype none
interface ipm_pix_if #(
  parameter int COORD_BITS = ipm_pkg::CoordBitsDef,
  parameter int PIXEL_BITS = ipm_pkg::PixelBitsDef
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] x_coord;
  logic [COORD_BITS-1:0] y_coord;
  logic [PIXEL_BITS-1:0] pixel_in;

  modport source (output valid, x_coord, y_coord, pixel_in, input ready);
  modport sink   (input valid, x_coord, y_coord, pixel_in, output ready);
endinterface
`default_nettype wire

@@ sv/ipm_res_if.sv @@
// Channel interface carrying one mapped bird's-eye result per beat.
`default_nettype none
interface ipm_res_if;
  logic                         valid;
  logic                         ready;
  logic                         valid_res;
  logic [ipm_pkg::RowW-1:0]     out_row;
  logic [ipm_pkg::ColW-1:0]     out_col;
  logic [ipm_pkg::PixOutW-1:0]  pixel_out;

  modport source (output valid, valid_res, out_row, out_col, pixel_out, input ready);
  modport sink   (input valid, valid_res, out_row, out_col, pixel_out, output ready);
endinterface
`default_nettype wire

@@ sv/ipm_div.sv @@
// Pipelined restoring divider that retires one quotient bit per stage.
`default_nettype none
module ipm_div #(
  parameter int N_W = 32,
  parameter int D_W = 16,
  parameter int Q_W = 8,
  parameter int S_W = 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic [N_W-1:0] dividend_i,
  input  logic [D_W-1:0] divisor_i,
  input  logic [S_W-1:0] side_i,
  output logic           valid_o,
  output logic [Q_W-1:0] quotient_o,
  output logic [S_W-1:0] side_o
);
  localparam int C_W = (N_W > D_W + Q_W) ? N_W : D_W + Q_W;

  logic [Q_W-1:0] vld_q;
  logic [C_W-1:0] rem_q  [Q_W];
  logic [Q_W-1:0] quo_q  [Q_W];
  logic [D_W-1:0] dvs_q  [Q_W];
  logic [S_W-1:0] side_q [Q_W];

  logic [Q_W-1:0] vld_in;
  logic [C_W-1:0] rem_in  [Q_W];
  logic [Q_W-1:0] quo_in  [Q_W];
  logic [D_W-1:0] dvs_in  [Q_W];
  logic [S_W-1:0] side_in [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic [C_W-1:0] trial;
    logic           ge;
    logic [C_W-1:0] rem_d;
    logic [Q_W-1:0] quo_d;

    if (k == 0) begin : g_head
      assign vld_in[0]  = valid_i;
      assign rem_in[0]  = C_W'(dividend_i);
      assign quo_in[0]  = '0;
      assign dvs_in[0]  = divisor_i;
      assign side_in[0] = side_i;
    end else begin : g_link
      assign vld_in[k]  = vld_q[k-1];
      assign rem_in[k]  = rem_q[k-1];
      assign quo_in[k]  = quo_q[k-1];
      assign dvs_in[k]  = dvs_q[k-1];
      assign side_in[k] = side_q[k-1];
    end

    // Bit Q_W-1-k of the quotient is decided here.
    always_comb begin
      trial = C_W'(dvs_in[k]) << (Q_W - 1 - k);
      ge    = rem_in[k] >= trial;
      rem_d = ge ? rem_in[k] - trial : rem_in[k];
      quo_d = quo_in[k];
      quo_d[Q_W-1-k] = ge;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        quo_q[k]  <= quo_d;
        dvs_q[k]  <= dvs_in[k];
        side_q[k] <= side_in[k];
      end
    end
  end

  assign valid_o    = vld_q[Q_W-1];
  assign quotient_o = quo_q[Q_W-1];
  assign side_o     = side_q[Q_W-1];
endmodule
`default_nettype wire

@@ sv/ipm_front.sv @@
// Front stages: depth numerator and denominator, sign fix, window test, row dividend.
`default_nettype none
module ipm_front #(
  parameter int COORD_BITS = ipm_pkg::CoordBitsDef,
  parameter int PIXEL_BITS = ipm_pkg::PixelBitsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [COORD_BITS-1:0]   x_i,
  input  logic [COORD_BITS-1:0]   y_i,
  input  logic [PIXEL_BITS-1:0]   pix_i,
  input  ipm_pkg::cfg_t           cfg_i,
  output logic                    valid_o,
  output logic [COORD_BITS-1:0]   x_o,
  output logic [PIXEL_BITS-1:0]   pix_o,
  output logic                    ok_o,
  output logic [COORD_BITS+32:0]  num_o,
  output logic [COORD_BITS+32:0]  den_o,
  output logic [COORD_BITS+43:0]  row_dvd_o
);
  localparam int PW = COORD_BITS + 32;
  localparam int SW = COORD_BITS + 34;
  localparam int ND = SW - 1;
  localparam int RW = SW + 10;

  logic [3:0] v_q;

  // Stage A: products with the row coordinate.
  logic signed [PW-1:0]  yhs_a_q, ycs_a_q;
  logic [COORD_BITS-1:0] x_a_q, x_b_q, x_c_q, x_d_q;
  logic [PIXEL_BITS-1:0] pix_a_q, pix_b_q, pix_c_q, pix_d_q;
  // Stage B: raw numerator and denominator.
  logic signed [SW-1:0]  num_b_q, den_b_q;
  // Stage C: denominator made non-negative.
  logic signed [SW-1:0]  num_c_q, den_c_q;
  // Stage D: window flag and row dividend.
  logic                  ok_d_q;
  logic [ND-1:0]         num_d_q, den_d_q;
  logic [RW-1:0]         rdv_d_q;

  logic signed [PW-1:0]   yhs_d, ycs_d;
  logic signed [SW-1:0]   num_b_d, den_b_d, num_c_d, den_c_d;
  logic signed [SW+3:0]   den10;
  logic                   ok_d;
  logic signed [RW-1:0]   rdv_d;

  always_comb begin
    yhs_d   = PW'($signed(y_i)) * PW'($signed(cfg_i.h_sin_tilt));
    ycs_d   = PW'($signed(y_i)) * PW'($signed(cfg_i.cos_tilt));
    num_b_d = SW'(yhs_a_q) + SW'($signed(cfg_i.f_h_cos_tilt));
    den_b_d = SW'($signed(cfg_i.f_sin_tilt)) - SW'(ycs_a_q);
    num_c_d = den_b_q[SW-1] ? -num_b_q : num_b_q;
    den_c_d = den_b_q[SW-1] ? -den_b_q : den_b_q;
    den10   = (SW+4)'(den_c_q) * (SW+4)'(ipm_pkg::DepthMax);
    ok_d    = (den_c_q != '0) && (cfg_i.focal_length != '0) &&
              (num_c_q > den_c_q) && ((SW+4)'(num_c_q) < den10);
    rdv_d   = RW'(den_c_q) * RW'(ipm_pkg::RowBase) - RW'(num_c_q) * RW'(ipm_pkg::Scale);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      yhs_a_q <= yhs_d;
      ycs_a_q <= ycs_d;
      x_a_q   <= x_i;
      pix_a_q <= pix_i;
      num_b_q <= num_b_d;
      den_b_q <= den_b_d;
      x_b_q   <= x_a_q;
      pix_b_q <= pix_a_q;
      num_c_q <= num_c_d;
      den_c_q <= den_c_d;
      x_c_q   <= x_b_q;
      pix_c_q <= pix_b_q;
      ok_d_q  <= ok_d;
      num_d_q <= num_c_q[ND-1:0];
      den_d_q <= den_c_q[ND-1:0];
      rdv_d_q <= rdv_d;
      x_d_q   <= x_c_q;
      pix_d_q <= pix_c_q;
    end
  end

  assign valid_o   = v_q[3];
  assign x_o       = x_d_q;
  assign pix_o     = pix_d_q;
  assign ok_o      = ok_d_q;
  assign num_o     = num_d_q;
  assign den_o     = den_d_q;
  assign row_dvd_o = rdv_d_q;
endmodule
`default_nettype wire

@@ sv/ipm_lat.sv @@
// Lateral stages: tilt correction of the depth, lateral product, window test, column dividend.
`default_nettype none
module ipm_lat #(
  parameter int COORD_BITS = ipm_pkg::CoordBitsDef,
  parameter int PIXEL_BITS = ipm_pkg::PixelBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [ipm_pkg::ZqW-1:0]       zq_i,
  input  logic [COORD_BITS-1:0]         x_i,
  input  logic [PIXEL_BITS-1:0]         pix_i,
  input  logic                          ok_i,
  input  logic [ipm_pkg::RowW-1:0]      row_i,
  input  ipm_pkg::cfg_t                 cfg_i,
  output logic                          valid_o,
  output logic                          ok_o,
  output logic [ipm_pkg::RowW-1:0]      row_o,
  output logic [PIXEL_BITS-1:0]         pix_o,
  output logic [ipm_pkg::ColDvdW-1:0]   col_dvd_o
);
  localparam int P_W  = ipm_pkg::ZqW + 1 + 32;
  localparam int T_W  = P_W - ipm_pkg::FracW + 1;
  localparam int XT_W = COORD_BITS + T_W;
  localparam int CD_W = XT_W + 9;

  logic [3:0] v_q;

  logic signed [P_W-1:0]      p_1_q;
  logic signed [T_W-1:0]      t_2_q;
  logic signed [XT_W-1:0]     xt_3_q;
  logic                       ok_1_q, ok_2_q, ok_3_q, ok_4_q;
  logic [ipm_pkg::RowW-1:0]   row_1_q, row_2_q, row_3_q, row_4_q;
  logic [PIXEL_BITS-1:0]      pix_1_q, pix_2_q, pix_3_q, pix_4_q;
  logic [COORD_BITS-1:0]      x_1_q, x_2_q;
  logic [ipm_pkg::ColDvdW-1:0] cdv_4_q;

  logic signed [P_W-1:0]  p_d, p_bias, p_sh;
  logic signed [T_W-1:0]  t_d;
  logic signed [XT_W-1:0] xt_d, axt;
  logic [XT_W-1:0]        fl3;
  logic                   ok_4_d;
  logic signed [CD_W-1:0] cdv_d;

  always_comb begin
    p_d    = P_W'($signed({1'b0, zq_i})) * P_W'($signed(cfg_i.cos_tilt));
    // Division by one in Q16.16 truncates toward zero.
    p_bias = p_1_q[P_W-1] ? p_1_q + P_W'(ipm_pkg::FracMask) : p_1_q;
    p_sh   = p_bias >>> ipm_pkg::FracW;
    t_d    = T_W'($signed(cfg_i.h_sin_tilt)) + $signed(p_sh[T_W-1:0]);
    xt_d   = XT_W'($signed(x_2_q)) * XT_W'(t_2_q);
    axt    = xt_3_q[XT_W-1] ? -xt_3_q : xt_3_q;
    fl3    = XT_W'(cfg_i.focal_length) * XT_W'(ipm_pkg::LatMax);
    ok_4_d = ok_3_q && ($unsigned(axt) < fl3);
    cdv_d  = CD_W'(cfg_i.focal_length) * CD_W'(ipm_pkg::ColBase) -
             CD_W'(xt_3_q) * CD_W'(ipm_pkg::Scale);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_1_q   <= p_d;
      ok_1_q  <= ok_i;
      row_1_q <= row_i;
      pix_1_q <= pix_i;
      x_1_q   <= x_i;
      t_2_q   <= t_d;
      ok_2_q  <= ok_1_q;
      row_2_q <= row_1_q;
      pix_2_q <= pix_1_q;
      x_2_q   <= x_1_q;
      xt_3_q  <= xt_d;
      ok_3_q  <= ok_2_q;
      row_3_q <= row_2_q;
      pix_3_q <= pix_2_q;
      ok_4_q  <= ok_4_d;
      cdv_4_q <= cdv_d[ipm_pkg::ColDvdW-1:0];
      row_4_q <= row_3_q;
      pix_4_q <= pix_3_q;
    end
  end

  assign valid_o   = v_q[3];
  assign ok_o      = ok_4_q;
  assign row_o     = row_4_q;
  assign pix_o     = pix_4_q;
  assign col_dvd_o = cdv_4_q;
endmodule
`default_nettype wire

@@ sv/ipm_pixel_mapper_top.sv @@
// Top level of the inverse perspective pixel mapper.
//
// One pixel beat enters on pix_in (signed camera-grid x and y relative to the
// principal point, plus its intensity) and exactly one result beat leaves on
// res_out, in the same order. A result carries valid_res, the bird's-eye row
// and column, and the intensity; when the pixel falls outside the ground
// window (1 < depth < 10, |lateral| < 3) or a denominator is zero, valid_res
// is low and row and column are zero.
// The camera terms are written through cfg_we_i / cfg_idx_i / cfg_wdata_i,
// one register per write; the user must do so only while no pixel is in
// flight, which the block does not enforce. Throughput is one pixel per clock
// while the receiver does not stall. A pixel passes 4 front stages, 20 stages
// of the depth divider (one quotient bit each), 4 lateral stages and 9 stages
// of the column divider from acceptance to res_out.
// The whole pipeline advances together. It moves whenever the final stage is
// empty or its result is being taken; while the receiver stalls a waiting
// result, every stage holds and pix_in.ready is low, so nothing is lost.
// Reset clears all valid bits and loads the camera terms with zero and the
// focal length with 1.0; the block accepts pixels right after reset.
`default_nettype none
module ipm_pixel_mapper_top #(
  parameter int COORD_BITS = ipm_pkg::CoordBitsDef,
  parameter int PIXEL_BITS = ipm_pkg::PixelBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ipm_pix_if.sink                       pix_in,
  ipm_res_if.source                     res_out,
  input  logic                          cfg_we_i,
  input  logic [ipm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ipm_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  localparam int ND = COORD_BITS + 33;
  localparam int RW = COORD_BITS + 44;
  localparam int SZ = COORD_BITS + PIXEL_BITS;
  localparam int SC = 1 + ipm_pkg::RowW + PIXEL_BITS;

  ipm_pkg::cfg_t cfg_q;

  // Configuration registers; writes to unused indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.h_sin_tilt   <= '0;
      cfg_q.cos_tilt     <= '0;
      cfg_q.f_h_cos_tilt <= '0;
      cfg_q.f_sin_tilt   <= '0;
      cfg_q.focal_length <= ipm_pkg::FocalReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ipm_pkg::REG_H_SIN_TILT:   cfg_q.h_sin_tilt   <= cfg_wdata_i;
        ipm_pkg::REG_COS_TILT:     cfg_q.cos_tilt     <= cfg_wdata_i;
        ipm_pkg::REG_F_H_COS_TILT: cfg_q.f_h_cos_tilt <= cfg_wdata_i;
        ipm_pkg::REG_F_SIN_TILT:   cfg_q.f_sin_tilt   <= cfg_wdata_i;
        ipm_pkg::REG_FOCAL_LENGTH: cfg_q.focal_length <= cfg_wdata_i[ipm_pkg::FocalW-1:0];
        default: ;
      endcase
    end
  end

  // Global advance: the final stage is free or being drained.
  logic en;
  assign en           = !res_out.valid || res_out.ready;
  assign pix_in.ready = en;

  logic                  f_valid, f_ok;
  logic [COORD_BITS-1:0] f_x;
  logic [PIXEL_BITS-1:0] f_pix;
  logic [ND-1:0]         f_num, f_den;
  logic [RW-1:0]         f_rdv;

  ipm_front #(
    .COORD_BITS(COORD_BITS),
    .PIXEL_BITS(PIXEL_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (pix_in.valid),
    .x_i       (pix_in.x_coord),
    .y_i       (pix_in.y_coord),
    .pix_i     (pix_in.pixel_in),
    .cfg_i     (cfg_q),
    .valid_o   (f_valid),
    .x_o       (f_x),
    .pix_o     (f_pix),
    .ok_o      (f_ok),
    .num_o     (f_num),
    .den_o     (f_den),
    .row_dvd_o (f_rdv)
  );

  // Depth in Q4.16 and the bird's-eye row run side by side.
  logic                     z_valid, r_valid, r_ok;
  logic [ipm_pkg::ZqW-1:0]  zq, row_q20;
  logic [SZ-1:0]            z_side;

  ipm_div #(
    .N_W(ND + ipm_pkg::FracW),
    .D_W(ND),
    .Q_W(ipm_pkg::ZqW),
    .S_W(SZ)
  ) u_div_depth (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (f_valid),
    .dividend_i ({f_num, ipm_pkg::FracW'(0)}),
    .divisor_i  (f_den),
    .side_i     ({f_x, f_pix}),
    .valid_o    (z_valid),
    .quotient_o (zq),
    .side_o     (z_side)
  );

  ipm_div #(
    .N_W(RW),
    .D_W(ND),
    .Q_W(ipm_pkg::ZqW),
    .S_W(1)
  ) u_div_row (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (f_valid),
    .dividend_i (f_rdv),
    .divisor_i  (f_den),
    .side_i     (f_ok),
    .valid_o    (r_valid),
    .quotient_o (row_q20),
    .side_o     (r_ok)
  );

  logic                         l_valid, l_ok;
  logic [ipm_pkg::RowW-1:0]     l_row;
  logic [PIXEL_BITS-1:0]        l_pix;
  logic [ipm_pkg::ColDvdW-1:0]  l_cdv;

  ipm_lat #(
    .COORD_BITS(COORD_BITS),
    .PIXEL_BITS(PIXEL_BITS)
  ) u_lat (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (z_valid && r_valid),
    .zq_i      (zq),
    .x_i       (z_side[SZ-1:PIXEL_BITS]),
    .pix_i     (z_side[PIXEL_BITS-1:0]),
    .ok_i      (r_ok),
    .row_i     (row_q20[ipm_pkg::RowW-1:0]),
    .cfg_i     (cfg_q),
    .valid_o   (l_valid),
    .ok_o      (l_ok),
    .row_o     (l_row),
    .pix_o     (l_pix),
    .col_dvd_o (l_cdv)
  );

  // The last divider stage doubles as the output register.
  logic                    c_valid;
  logic [ipm_pkg::ColW-1:0] col;
  logic [SC-1:0]           c_side;

  ipm_div #(
    .N_W(ipm_pkg::ColDvdW),
    .D_W(ipm_pkg::FocalW),
    .Q_W(ipm_pkg::ColW),
    .S_W(SC)
  ) u_div_col (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (l_valid),
    .dividend_i (l_cdv),
    .divisor_i  (cfg_q.focal_length),
    .side_i     ({l_ok, l_row, l_pix}),
    .valid_o    (c_valid),
    .quotient_o (col),
    .side_o     (c_side)
  );

  logic                     o_ok;
  logic [ipm_pkg::RowW-1:0] o_row;
  logic [PIXEL_BITS-1:0]    o_pix;
  assign {o_ok, o_row, o_pix} = c_side;

  assign res_out.valid     = c_valid;
  assign res_out.valid_res = o_ok;
  assign res_out.out_row   = o_ok ? o_row : '0;
  assign res_out.out_col   = o_ok ? col : '0;
  assign res_out.pixel_out = ipm_pkg::PixOutW'(o_pix);
endmodule
`default_nettype wire

@@ sv/ipm_checker.sv @@
// Port-level checker for the pixel mapper and its bind to the top level.
`default_nettype none
module ipm_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic                         valid_res_i,
  input logic [ipm_pkg::RowW-1:0]     out_row_i,
  input logic [ipm_pkg::ColW-1:0]     out_col_i,
  input logic [ipm_pkg::PixOutW-1:0]  pixel_out_i
);
  // A stalled result beat stays put.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(valid_res_i) &&
    $stable(out_row_i) && $stable(out_col_i) && $stable(pixel_out_i))
    else $error("result beat changed while stalled");

  // The pipeline freezes while its last result is stalled.
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("pixel accepted while output stalled");

  // A rejected pixel carries no position.
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !valid_res_i |-> out_row_i == '0 && out_col_i == '0)
    else $error("rejected pixel has nonzero position");

  // A kept pixel lands inside the bird's-eye image.
  a_in_image: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && valid_res_i |-> out_row_i <= ipm_pkg::RowW'(449) &&
    out_col_i <= ipm_pkg::ColW'(299))
    else $error("kept pixel outside bird's-eye image");
endmodule

bind ipm_pixel_mapper_top ipm_checker u_ipm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (pix_in.ready),
  .out_valid_i (res_out.valid),
  .out_ready_i (res_out.ready),
  .valid_res_i (res_out.valid_res),
  .out_row_i   (res_out.out_row),
  .out_col_i   (res_out.out_col),
  .pixel_out_i (res_out.pixel_out)
);
`default_nettype wire

@@ tb/sv/ipm_mapper_checker.sv @@
// Checker that predicts each mapped bird's-eye result and compares it with the block output.
module ipm_mapper_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ipm_pix_if                            pix,
  ipm_res_if                            res,
  input  logic                          cfg_we_i,
  input  logic [ipm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ipm_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output int                            errors_o,
  output int                            pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ipm_pkg::*;

  typedef struct {
    bit                valid_res;
    bit [RowW-1:0]     row;
    bit [ColW-1:0]     col;
    bit [PixOutW-1:0]  pix;
  } mapped_t;

  logic [31:0]       hs_q, cs_q, fhc_q, fs_q;
  logic [FocalW-1:0] fl_q;
  mapped_t           mapped_q[$];
  int                errors;

  assign errors_o  = errors;
  assign pending_o = mapped_q.size();

  // Exact fixed-point ground projection of one camera pixel.
  function automatic mapped_t map_pixel(logic [CoordBitsDef-1:0] x, logic [CoordBitsDef-1:0] y,
                                        logic [PixelBitsDef-1:0] p);
    mapped_t m;
    longint  xs, ys, hs, cs, fhc, fs, fl, num, den, q, r, zq, tl, xt, axt;
    xs  = longint'($signed(x));
    ys  = longint'($signed(y));
    hs  = longint'($signed(hs_q));
    cs  = longint'($signed(cs_q));
    fhc = longint'($signed(fhc_q));
    fs  = longint'($signed(fs_q));
    fl  = longint'(fl_q);
    num = ys * hs + fhc;
    den = fs - ys * cs;
    m.valid_res = 0;
    m.row = '0;
    m.col = '0;
    m.pix = p;
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    if (den != 0 && fl != 0 && num > den && num < 10 * den) begin
      q   = num / den;
      r   = num % den;
      zq  = q * 65536 + (r * 65536) / den;
      tl  = hs + (zq * cs) / 65536;
      xt  = xs * tl;
      axt = (xt < 0) ? -xt : xt;
      if (axt < 3 * fl) begin
        m.valid_res = 1;
        m.row = RowW'((500 * den - 50 * num) / den);
        m.col = ColW'((150 * fl - 50 * xt) / fl);
      end
    end
    return m;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    mapped_t e;
    if (!rst_ni) begin
      hs_q  <= '0;
      cs_q  <= '0;
      fhc_q <= '0;
      fs_q  <= '0;
      fl_q  <= FocalReset;
      errors = 0;
      mapped_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_H_SIN_TILT:   hs_q  <= cfg_wdata_i;
          REG_COS_TILT:     cs_q  <= cfg_wdata_i;
          REG_F_H_COS_TILT: fhc_q <= cfg_wdata_i;
          REG_F_SIN_TILT:   fs_q  <= cfg_wdata_i;
          REG_FOCAL_LENGTH: fl_q  <= cfg_wdata_i[FocalW-1:0];
          default: ;
        endcase
      end
      if (pix.valid && pix.ready)
        mapped_q.push_back(map_pixel(pix.x_coord, pix.y_coord, pix.pixel_in));
      if (res.valid && res.ready) begin
        if (mapped_q.size() == 0) begin
          errors++;
          $display("%t: result beat with nothing expected: valid_res=%0d row=%0d col=%0d pix=%0d",
                   $realtime, res.valid_res, res.out_row, res.out_col, res.pixel_out);
        end else begin
          e = mapped_q.pop_front();
          if (res.valid_res !== e.valid_res || res.out_row !== e.row ||
              res.out_col !== e.col || res.pixel_out !== e.pix) begin
            errors++;
            $display("%t: mismatch expected valid_res=%0d row=%0d col=%0d pix=%0d", $realtime,
                     e.valid_res, e.row, e.col, e.pix);
            $display("%t:          actual   valid_res=%0d row=%0d col=%0d pix=%0d", $realtime,
                     res.valid_res, res.out_row, res.out_col, res.pixel_out);
          end
        end
      end
    end
  end
endmodule

@@ tb/sv/ipm_pixel_mapper_top_tb.sv @@
// Testbench top for the pixel mapper: stimulus, receiver stalls, watchdog and verdict.
module ipm_pixel_mapper_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ipm_pkg::*;

  // Settle time after drain, longer than a pixel takes to cross the pipeline.
  localparam int SettleCycles = 45;
  localparam int StallLimit   = 5000;
  localparam int HoldCycles   = 300;

  // A plausible camera: height 1.5, tilt about 26 degrees, focal length 500 pixels.
  localparam logic [31:0] CamHsin  = 32'd42860;
  localparam logic [31:0] CamCos   = 32'd58982;
  localparam logic [31:0] CamFhcos = 32'd44236800;
  localparam logic [31:0] CamFsin  = 32'd14286848;
  localparam logic [31:0] CamFocal = 32'd32768000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  int   errors, pending;
  bit   hold_req = 0;
  int   burst_left = 0;
  int   idle_cycles = 0;

  ipm_pix_if pix ();
  ipm_res_if res ();

  ipm_pixel_mapper_top dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .pix_in     (pix),
    .res_out    (res),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  ipm_mapper_checker checker_i (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .pix        (pix),
    .res        (res),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  always #5 clk = ~clk;

  // The watchdog counts cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if ((pix.valid && pix.ready) || (res.valid && res.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // The receiver follows a duty-cycle pattern that is redrawn periodically; a full
  // duty cycle gives stretches with no stall at all. A hold-off request overrides it
  // with a long run of low ready so that the pipeline fills and stalls its input.
  initial begin
    int period, duty, cyc, hold_cnt;
    res.ready = 1'b0;
    period = 1;
    duty = 1;
    cyc = 0;
    hold_cnt = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 0;
        hold_cnt = HoldCycles;
      end
      if (cyc % 64 == 0) begin
        period = $urandom_range(1, 8);
        duty = ($urandom_range(0, 3) == 0) ? period : $urandom_range(0, period);
      end
      cyc++;
      if (hold_cnt > 0) begin
        hold_cnt--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= ((cyc % period) < duty);
      end
    end
  end

  // Writes one register and leaves cfg_we high, so that calls in a row write on consecutive
  // cycles; idx is a plain vector so that indexes past the register list can be exercised too.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk);
  endtask

  task automatic write_camera(logic [31:0] hs, logic [31:0] cs, logic [31:0] fhc,
                              logic [31:0] fs, logic [31:0] fl);
    write_reg(REG_H_SIN_TILT, hs);
    write_reg(REG_COS_TILT, cs);
    write_reg(REG_F_H_COS_TILT, fhc);
    write_reg(REG_F_SIN_TILT, fs);
    write_reg(REG_FOCAL_LENGTH, fl);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Blocks until every expected result has come back and the pipeline has drained.
  task automatic drain();
    pix.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // Offers one pixel beat and returns on the falling edge after it is accepted.
  // Beats come in bursts; between bursts valid may drop for a random gap.
  task automatic send_pixel(int x, int y, int p);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        pix.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    pix.valid    <= 1'b1;
    pix.x_coord  <= CoordBitsDef'(x);
    pix.y_coord  <= CoordBitsDef'(y);
    pix.pixel_in <= PixelBitsDef'(p);
    do @(posedge clk); while (!pix.ready);
    @(negedge clk);
  endtask

  // Mostly pixels near the principal point, where the plausible camera sees the ground
  // window, and the rest anywhere on the full coordinate range.
  task automatic send_random(int n);
    repeat (n) begin
      if ($urandom_range(0, 3) != 0)
        send_pixel($urandom_range(0, 700) - 350, $urandom_range(0, 400) - 250,
                   $urandom_range(0, 255));
      else
        send_pixel($urandom_range(0, 2047) - 1024, $urandom_range(0, 2047) - 1024,
                   $urandom_range(0, 255));
    end
  endtask

  function automatic logic [31:0] jitter(logic [31:0] v);
    return v + 32'($signed($urandom_range(0, 2 * (v >> 3)) - int'(v >> 3)));
  endfunction

  initial begin
    pix.valid    = 1'b0;
    pix.x_coord  = '0;
    pix.y_coord  = '0;
    pix.pixel_in = '0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Reset terms: the depth denominator is zero, so nothing is valid.
    send_pixel(0, 0, 0);
    send_pixel(-1024, 1023, 255);
    send_random(40);
    drain();

    // Plausible camera. A write to an index past the list must change nothing.
    write_camera(CamHsin, CamCos, CamFhcos, CamFsin, CamFocal);
    write_reg(3'd5, 32'hFFFF_FFFF);
    write_reg(3'd7, 32'h8000_0000);
    cfg_we <= 1'b0;
    @(negedge clk);
    send_pixel(0, 0, 128);
    send_pixel(-1024, -1024, 0);
    send_pixel(1023, 1023, 255);
    send_pixel(-1024, 0, 1);
    send_pixel(1023, 0, 254);
    send_pixel(0, -1024, 85);
    send_pixel(0, 1023, 170);
    send_pixel(100, -100, 7);
    send_pixel(-100, 100, 200);
    send_pixel(435, 0, 33);
    send_pixel(-436, 0, 66);
    send_pixel(0, -150, 99);
    send_pixel(0, 150, 15);
    send_random(150);
    // Long receiver hold-off while the sender keeps offering.
    hold_req = 1;
    send_random(150);
    // The sender pauses until every result is back, then goes on.
    pix.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    send_random(100);
    drain();

    // Horizon at y = 100: the denominator vanishes there.
    write_camera(CamHsin, 32'h0001_0000, CamFhcos, 32'd6553600, CamFocal);
    send_pixel(0, 100, 11);
    send_pixel(50, 100, 22);
    send_pixel(0, 99, 44);
    send_pixel(0, 101, 88);
    send_random(150);
    drain();

    // Extremes of every register, in both directions.
    write_camera(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_pixel(-1024, -1024, 0);
    send_pixel(1023, 1023, 255);
    send_random(150);
    drain();
    write_camera(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1);
    send_pixel(-1024, 1023, 0);
    send_pixel(1023, -1024, 255);
    send_random(150);
    drain();

    // A zero focal length makes every pixel invalid.
    write_camera(CamHsin, CamCos, CamFhcos, CamFsin, 32'd0);
    send_pixel(0, 0, 1);
    send_random(20);
    drain();

    // Cameras scattered around the plausible one.
    repeat (4) begin
      write_camera(jitter(CamHsin), jitter(CamCos), jitter(CamFhcos), jitter(CamFsin),
                   jitter(CamFocal));
      send_random(100);
      drain();
    end

    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end
endmodule

@@ files.f @@
sv/ipm_pkg.sv
sv/ipm_pix_if.sv
sv/ipm_res_if.sv
sv/ipm_div.sv
sv/ipm_front.sv
sv/ipm_lat.sv
sv/ipm_pixel_mapper_top.sv
sv/ipm_checker.sv
tb/sv/ipm_mapper_checker.sv
tb/sv/ipm_pixel_mapper_top_tb.sv
